// ----- hdl/gb3_pkg.sv -----
`default_nettype none
package gb3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int PIX_W      = 8;
	localparam int LINE_W     = 2 * PIX_W;
	localparam int NRES       = 4;
	localparam int SUM_W      = PIX_W + 4;

	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_LSB = 2;

	// register index codes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0] WIDTH_RST  = FW_W'(1024);
	localparam logic [FH_W-1:0] HEIGHT_RST = FH_W'(1024);

	// result slots caused by one input, in emission order
	localparam logic [1:0] RES_ABOVE_MID  = 2'd0;
	localparam logic [1:0] RES_ABOVE_EDGE = 2'd1;
	localparam logic [1:0] RES_OWN_MID    = 2'd2;
	localparam logic [1:0] RES_OWN_EDGE   = 2'd3;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [8:0] win_t;

	typedef struct packed {
		logic [FW_W-1:0] eff_w;
		logic [FH_W-1:0] eff_h;
		logic            clr;
	} cfg_t;

	typedef struct packed {
		logic row_ge1;
		logic row_ge2;
		logic first_col;
		logic last_col;
		logic last_row;
	} pos_t;

	typedef struct packed {
		win_t             win;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [NRES-1:0]  pend;
	} item_t;

	// 1-2-1 by 1-2-1 kernel; bot picks rows 1,2,2 and rgt picks cols 1,2,2
	function automatic pix_t blur(win_t w, logic bot, logic rgt);
		int ri [3];
		int ci [3];
		logic [PIX_W+1:0] rs [3];
		logic [SUM_W-1:0] s;
		ri[0] = bot ? 1 : 0;
		ri[1] = bot ? 2 : 1;
		ri[2] = 2;
		ci[0] = rgt ? 1 : 0;
		ci[1] = rgt ? 2 : 1;
		ci[2] = 2;
		for (int k = 0; k < 3; k++) begin
			rs[k] = (PIX_W+2)'(w[ri[k]*3 + ci[0]]) + {1'b0, w[ri[k]*3 + ci[1]], 1'b0}
				+ (PIX_W+2)'(w[ri[k]*3 + ci[2]]);
		end
		s = SUM_W'(rs[0]) + {rs[1], 1'b0} + SUM_W'(rs[2]) + SUM_W'(8);
		return s[SUM_W-1:4];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/gb3_if.sv -----
`default_nettype none
interface gb3_pix_if;
	logic                 valid;
	logic                 ready;
	logic [7:0]           pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

interface gb3_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  blurred_value;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic        last_of_run;
	logic        frame_done;

	modport source (output valid, output blurred_value, output out_row, output out_col,
		output last_of_run, output frame_done, input ready);
	modport sink   (input valid, input blurred_value, input out_row, input out_col,
		input last_of_run, input frame_done, output ready);
endinterface
`default_nettype wire

// ----- hdl/gb3_cfg.sv -----
`default_nettype none
module gb3_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gb3_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [gb3_pkg::PDATA_W-1:0]  pwdata,
	output logic      [gb3_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output gb3_pkg::cfg_t                     cfg
);
	import gb3_pkg::*;

	logic [FW_W-1:0] width_q;
	logic [FH_W-1:0] height_q;
	logic            wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr) begin
			unique case (paddr[REG_IDX_LSB])
				REG_WIDTH:  width_q  <= pwdata[FW_W-1:0];
				REG_HEIGHT: height_q <= pwdata[FH_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_IDX_LSB])
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	// zero means one, oversize saturates
	always_comb begin
		priority if (width_q == '0)
			cfg.eff_w = FW_W'(1);
		else if (width_q > FW_W'(MAX_WIDTH))
			cfg.eff_w = FW_W'(MAX_WIDTH);
		else
			cfg.eff_w = width_q;
		priority if (height_q == '0)
			cfg.eff_h = FH_W'(1);
		else if (height_q > FH_W'(MAX_HEIGHT))
			cfg.eff_h = FH_W'(MAX_HEIGHT);
		else
			cfg.eff_h = height_q;
		cfg.clr = wr;
	end

endmodule
`default_nettype wire

// ----- hdl/gb3_window.sv -----
`default_nettype none
module gb3_window (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       acc,
	input  wire logic [gb3_pkg::PIX_W-1:0]  pix,
	input  wire logic [gb3_pkg::COL_W-1:0]  col,
	input  wire logic [gb3_pkg::ROW_W-1:0]  row,
	input  wire gb3_pkg::pos_t              pos,
	input  wire logic                       can_load,
	output logic                            ready,
	output gb3_pkg::item_t                  item,
	output logic                            item_load
);
	import gb3_pkg::*;

	logic [LINE_W-1:0] mem [MAX_WIDTH];

	logic              v_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	pos_t              pos_s1;
	logic [LINE_W-1:0] rd_s1;
	logic              hz_s1;
	logic [LINE_W-1:0] fwd_s1;
	win_t              win_q;

	logic              adv;
	logic [LINE_W-1:0] line;
	pix_t              older, newer, top, mid;
	pix_t              v [3];
	win_t              win_n;
	logic [LINE_W-1:0] wr_data;

	assign adv   = v_s1 & can_load;
	assign ready = ~v_s1 | adv;

	// a write to the same column lands on the edge that reads it (one-pixel rows)
	assign line    = hz_s1 ? fwd_s1 : rd_s1;
	assign older   = line[LINE_W-1:PIX_W];
	assign newer   = line[PIX_W-1:0];
	assign mid     = pos_s1.row_ge1 ? newer : pix_s1;
	assign top     = pos_s1.row_ge2 ? older : mid;
	assign wr_data = {newer, pix_s1};

	always_comb begin
		v[0] = top;
		v[1] = mid;
		v[2] = pix_s1;
		for (int k = 0; k < 3; k++) begin
			if (pos_s1.first_col) begin
				win_n[k*3]     = v[k];
				win_n[k*3 + 1] = v[k];
			end else begin
				win_n[k*3]     = win_q[k*3 + 1];
				win_n[k*3 + 1] = win_q[k*3 + 2];
			end
			win_n[k*3 + 2] = v[k];
		end
	end

	always_comb begin
		item.win = win_n;
		item.row = row_s1;
		item.col = col_s1;
		item.pend[RES_ABOVE_MID]  = pos_s1.row_ge1 & ~pos_s1.first_col;
		item.pend[RES_ABOVE_EDGE] = pos_s1.row_ge1 & pos_s1.last_col;
		item.pend[RES_OWN_MID]    = pos_s1.last_row & ~pos_s1.first_col;
		item.pend[RES_OWN_EDGE]   = pos_s1.last_row & pos_s1.last_col;
	end
	assign item_load = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			hz_s1 <= 1'b0;
			win_q <= '0;
		end else begin
			if (acc)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;
			if (acc)
				hz_s1 <= adv & (col == col_s1);
			if (adv)
				win_q <= win_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1 <= pix;
			col_s1 <= col;
			row_s1 <= row;
			pos_s1 <= pos;
		end
		if (adv)
			fwd_s1 <= wr_data;
	end

	// line stores: older row in the upper byte, newer row in the lower byte
	always_ff @(posedge clk) begin
		if (acc)
			rd_s1 <= mem[col];
		if (adv)
			mem[col_s1] <= wr_data;
	end

endmodule
`default_nettype wire

// ----- hdl/gb3_emit.sv -----
`default_nettype none
module gb3_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire gb3_pkg::item_t  item,
	input  wire logic            item_load,
	output logic                 can_load,
	gb3_res_if.source            results
);
	import gb3_pkg::*;

	logic [NRES-1:0]  pend_s2;
	win_t             win_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;

	logic             ov_q;
	logic [PIX_W-1:0] val_q;
	logic [ROW_W-1:0] orow_q;
	logic [COL_W-1:0] ocol_q;
	logic             last_q;
	logic             done_q;

	logic [1:0]       idx;
	logic [NRES-1:0]  oh;
	logic [NRES-1:0]  rest;
	logic             emit;

	always_comb begin
		priority if (pend_s2[RES_ABOVE_MID])
			idx = RES_ABOVE_MID;
		else if (pend_s2[RES_ABOVE_EDGE])
			idx = RES_ABOVE_EDGE;
		else if (pend_s2[RES_OWN_MID])
			idx = RES_OWN_MID;
		else
			idx = RES_OWN_EDGE;
	end

	assign oh       = NRES'(1) << idx;
	assign rest     = pend_s2 & ~oh;
	assign emit     = (pend_s2 != '0) & (~ov_q | results.ready);
	assign can_load = (pend_s2 == '0) | (emit & (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (item_load)
				pend_s2 <= item.pend;
			else if (emit)
				pend_s2 <= rest;
			if (emit)
				ov_q <= 1'b1;
			else if (results.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_load) begin
			win_s2 <= item.win;
			row_s2 <= item.row;
			col_s2 <= item.col;
		end
		if (emit) begin
			val_q  <= blur(win_s2, idx[1], idx[0]);
			orow_q <= idx[1] ? row_s2 : row_s2 - ROW_W'(1);
			ocol_q <= idx[0] ? col_s2 : col_s2 - COL_W'(1);
			last_q <= (rest == '0);
			done_q <= (idx == RES_OWN_EDGE);
		end
	end

	assign results.valid         = ov_q;
	assign results.blurred_value = val_q;
	assign results.out_row       = orow_q;
	assign results.out_col       = ocol_q;
	assign results.last_of_run   = last_q;
	assign results.frame_done    = done_q;

endmodule
`default_nettype wire

// ----- hdl/gaussian_blur_3x3_clamp.sv -----
// channel   | dir | beat contents
// ----------+-----+--------------------------------------------------------
// pixels    | in  | pixel_value, raster order
// results   | out | blurred_value, out_row, out_col, last_of_run, frame_done
// apb       | in  | frame_width at 0x0, frame_height at 0x4
//
// one pixel accepted per cycle; results pass the window, result and output registers,
// one result beat per cycle while ready is high; a pixel with several results stalls input
// line stores are a single 1024 x 16 memory, read on accept, written as the pixel moves on
// no clearing pass: border replication keeps unwritten line entries out of the sums
// a register write restarts the frame at row 0, column 0
`default_nettype none
module gaussian_blur_3x3_clamp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	gb3_pix_if.sink                           pixels,
	gb3_res_if.source                         results,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gb3_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [gb3_pkg::PDATA_W-1:0]  pwdata,
	output logic      [gb3_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);
	import gb3_pkg::*;

	cfg_t             cfg;
	pos_t             pos;
	item_t            item;
	logic             item_load;
	logic             can_load;
	logic             in_ready;
	logic             accept;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	gb3_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign pixels.ready = in_ready;
	assign accept       = pixels.valid & in_ready;

	always_comb begin
		pos.row_ge1   = (row_q != '0);
		pos.row_ge2   = (row_q > ROW_W'(1));
		pos.first_col = (col_q == '0);
		pos.last_col  = ({1'b0, col_q} == cfg.eff_w - FW_W'(1));
		pos.last_row  = ({1'b0, row_q} == cfg.eff_h - FH_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.clr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	gb3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (accept),
		.pix       (pixels.pixel_value),
		.col       (col_q),
		.row       (row_q),
		.pos       (pos),
		.can_load  (can_load),
		.ready     (in_ready),
		.item      (item),
		.item_load (item_load)
	);

	gb3_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_load (item_load),
		.can_load  (can_load),
		.results   (results)
	);

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.frame_done |-> results.last_of_run)
		else $error("frame_done without last_of_run");

	a_done_col: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.frame_done |->
			results.out_col == COL_W'(cfg.eff_w - FW_W'(1)))
		else $error("frame_done away from last column");

	a_done_row: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.frame_done |->
			results.out_row == ROW_W'(cfg.eff_h - FH_W'(1)))
		else $error("frame_done away from last row");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		item_load |-> can_load)
		else $error("item loaded into busy result stage");

endmodule
`default_nettype wire

// ----- tb/tb_gaussian_blur_3x3_clamp.sv -----
`timescale 1ns / 1ps
module tb_gaussian_blur_3x3_clamp;
	import gb3_pkg::*;

	typedef struct {
		logic [7:0]  value;
		logic [11:0] row;
		logic [9:0]  col;
		logic        last;
		logic        done;
	} blur_res_t;

	typedef enum {PAT_RANDOM, PAT_ALT, PAT_WHITE} pix_pattern_e;

	class blur_scoreboard;
		logic [FW_W-1:0] width_reg;
		logic [FH_W-1:0] height_reg;
		logic [7:0]      line_old [MAX_WIDTH];
		logic [7:0]      line_new [MAX_WIDTH];
		logic [7:0]      win [3][3];
		int unsigned     row;
		int unsigned     col;
		blur_res_t       blurred_q [$];
		int unsigned     mismatches;

		function new();
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			row = 0;
			col = 0;
			mismatches = 0;
			foreach (win[i, j]) win[i][j] = '0;
			foreach (line_old[i]) begin
				line_old[i] = '0;
				line_new[i] = '0;
			end
		endfunction

		function void set_reg(logic idx, logic [31:0] v);
			if (idx == REG_WIDTH) width_reg = v[FW_W-1:0];
			else height_reg = v[FH_W-1:0];
			row = 0;
			col = 0;
		endfunction

		// t,m,b pick window rows; l,c,r pick window columns
		function logic [7:0] smooth(int t, int m, int b, int l, int c, int r);
			int rsel [3];
			int s;
			rsel[0] = t;
			rsel[1] = m;
			rsel[2] = b;
			s = 0;
			for (int k = 0; k < 3; k++)
				s += ((k == 1) ? 2 : 1) * (int'(win[rsel[k]][l]) + 2 * int'(win[rsel[k]][c])
					+ int'(win[rsel[k]][r]));
			return 8'((s + 8) >> 4);
		endfunction

		function blur_res_t make_res(logic [7:0] v, int unsigned r, int unsigned c, bit done);
			blur_res_t res;
			res.value = v;
			res.row   = 12'(r);
			res.col   = 10'(c);
			res.last  = 1'b0;
			res.done  = done;
			return res;
		endfunction

		function void note_pixel(logic [7:0] p);
			int unsigned w;
			int unsigned h;
			logic [7:0]  col_in [3];
			blur_res_t   run [$];
			w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
			h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
			if (col >= w || row >= h) begin
				row = 0;
				col = 0;
			end
			// rows missing above the frame replicate the nearest one
			col_in[2] = p;
			col_in[1] = (row >= 1) ? line_new[col] : p;
			col_in[0] = (row >= 2) ? line_old[col] : col_in[1];
			line_old[col] = line_new[col];
			line_new[col] = p;
			for (int k = 0; k < 3; k++) begin
				if (col == 0) begin
					win[k][0] = col_in[k];
					win[k][1] = col_in[k];
				end else begin
					win[k][0] = win[k][1];
					win[k][1] = win[k][2];
				end
				win[k][2] = col_in[k];
			end
			if (row >= 1) begin
				if (col >= 1) run.push_back(make_res(smooth(0, 1, 2, 0, 1, 2), row - 1, col - 1, 0));
				if (col == w - 1) run.push_back(make_res(smooth(0, 1, 2, 1, 2, 2), row - 1, col, 0));
			end
			if (row == h - 1) begin
				if (col >= 1) run.push_back(make_res(smooth(1, 2, 2, 0, 1, 2), row, col - 1, 0));
				if (col == w - 1) run.push_back(make_res(smooth(1, 2, 2, 1, 2, 2), row, col, 1));
			end
			if (run.size() > 0) run[run.size() - 1].last = 1'b1;
			foreach (run[i]) blurred_q.push_back(run[i]);
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function int unsigned pending();
			return blurred_q.size();
		endfunction

		function void check_result(logic [7:0] v, logic [11:0] r, logic [9:0] c, logic last,
			logic done);
			blur_res_t want;
			if (blurred_q.size() == 0) begin
				$error("unexpected result beat: row %0d col %0d value %0d", r, c, v);
				mismatches++;
				return;
			end
			want = blurred_q.pop_front();
			if (v !== want.value) begin
				$error("blurred_value: expected %0d, got %0d", want.value, v);
				mismatches++;
			end
			if (r !== want.row) begin
				$error("out_row: expected %0d, got %0d", want.row, r);
				mismatches++;
			end
			if (c !== want.col) begin
				$error("out_col: expected %0d, got %0d", want.col, c);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last_of_run: expected %0d, got %0d", want.last, last);
				mismatches++;
			end
			if (done !== want.done) begin
				$error("frame_done: expected %0d, got %0d", want.done, done);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	bit                  src_idle = 1'b1;
	bit                  snk_idle = 1'b1;
	int unsigned         stall_left = 0;

	blur_scoreboard sb = new();

	gb3_pix_if pix_ch ();
	gb3_res_if res_ch ();

	gaussian_blur_3x3_clamp uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.results (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.blurred_value, res_ch.out_row, res_ch.out_col,
				res_ch.last_of_run, res_ch.frame_done);
	end

	// result back-pressure
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				if (snk_idle && $urandom_range(0, 2) == 0) stall_left = pick_gap();
			end
		end
	end

	// transfers run back to back; check_regs returns the bus to idle
	task automatic reg_write(input logic idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx) << REG_IDX_LSB;
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic reg_read(input logic idx, input logic [31:0] want, input string name);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'(idx) << REG_IDX_LSB;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$error("%s: expected %0d, got %0d", name, want, prdata);
			sb.mismatches++;
		end
		@(negedge clk);
	endtask

	task automatic check_regs();
		reg_read(REG_WIDTH, 32'(sb.width_reg), "frame_width");
		reg_read(REG_HEIGHT, 32'(sb.height_reg), "frame_height");
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_pixel(input logic [7:0] p);
		int unsigned g;
		g = src_idle ? pick_gap() : 0;
		if (g > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel_value <= p;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		sb.note_pixel(p);
		@(negedge clk);
	endtask

	// pixels that emit nothing may still be in flight after the last result
	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_phase(input int unsigned wv, input int unsigned hv, input int unsigned n,
		input pix_pattern_e pat);
		logic [7:0] p;
		settle();
		src_idle = ($urandom_range(0, 3) != 0);
		snk_idle = ($urandom_range(0, 3) != 0);
		reg_write(REG_WIDTH, wv);
		reg_write(REG_HEIGHT, hv);
		check_regs();
		for (int unsigned i = 0; i < n; i++) begin
			case (pat)
				PAT_ALT: begin
					p = (i % 2) ? 8'hFF : 8'h00;
				end
				PAT_WHITE: begin
					p = 8'hFF;
				end
				default: begin
					if ($urandom_range(0, 7) == 0) p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					else p = 8'($urandom_range(0, 255));
				end
			endcase
			send_pixel(p);
		end
		pix_ch.valid <= 1'b0;
	endtask

	initial begin
		int unsigned fed;
		int unsigned w;
		int unsigned h;
		int unsigned n;
		pix_ch.valid       = 1'b0;
		pix_ch.pixel_value = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_regs();

		// small frames, extreme pixels, single row and single column
		run_phase(3, 3, 9, PAT_ALT);
		run_phase(2, 2, 4, PAT_WHITE);
		run_phase(1, 1, 2, PAT_ALT);
		run_phase(2, 1, 2, PAT_ALT);
		run_phase(1, 3, 3, PAT_RANDOM);
		// zero sizes behave as one
		run_phase(0, 0, 2, PAT_WHITE);

		// oversize values saturate, and the maximum sizes pass unchanged
		run_phase(2047, 1, 40, PAT_RANDOM);
		run_phase(1, 8191, 40, PAT_RANDOM);
		run_phase(MAX_WIDTH, MAX_HEIGHT, 24, PAT_RANDOM);

		fed = 0;
		while (fed < 150) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			n = w * h * $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w * h);
			run_phase(w, h, n, PAT_RANDOM);
			fed += n;
		end

		settle();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/gb3_pkg.sv
hdl/gb3_if.sv
hdl/gb3_cfg.sv
hdl/gb3_window.sv
hdl/gb3_emit.sv
hdl/gaussian_blur_3x3_clamp.sv
tb/tb_gaussian_blur_3x3_clamp.sv
